[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(label, clk, rst, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

[design/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Constants, request codes and controller/datapath interface types of the
// sector cache tag and clock replacement engine.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

  localparam int SCC_ENTRIES = 64;
  localparam int FUNC_W      = 2;
  localparam int SECTOR_W    = 32;
  localparam int OUT_IDX_W   = 6;
  localparam int MAX_OUT     = 64;
  localparam int K_W         = $clog2(MAX_OUT) + 1;

  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

  typedef struct packed {
    logic load_req;
    logic scan_step;
    logic sweep_start;
    logic sweep_step;
    logic hit_commit;
    logic miss_commit;
    logic fl_step;
    logic fl_take;
    logic fl_finish;
  } scc_cmd_t;

  typedef struct packed {
    logic match;
    logic scan_end;
    logic victim;
    logic fl_dirty;
    logic idx_end;
    logic k_limit;
    logic pend_valid;
    logic out_free;
  } scc_status_t;

endpackage

`default_nettype wire

[design/scc_ctrl.sv]
// ----------------------------------------------------------------------------
// scc_ctrl
// Request sequencer: tag lookup scan, clock sweep, refill and flush walk.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_ctrl
  import scc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic [FUNC_W-1:0] func,
  output logic                   req_stall,
  input  wire scc_status_t       st,
  output scc_cmd_t               cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_LOOKUP  = 8'b0000_0010,
    S_HIT_WR  = 8'b0000_0100,
    S_SWEEP   = 8'b0000_1000,
    S_MISS_WR = 8'b0001_0000,
    S_FL_SCAN = 8'b0010_0000,
    S_FL_TAKE = 8'b0100_0000,
    S_FL_END  = 8'b1000_0000
  } scc_state_t;

  scc_state_t state, state_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          case (func) inside
            FUNC_READ, FUNC_WRITE: state_next = S_LOOKUP;
            FUNC_FLUSH:            state_next = S_FL_SCAN;
            default:               state_next = S_IDLE;
          endcase
        end
      end
      S_LOOKUP: begin
        if (st.match) begin
          state_next = S_HIT_WR;
        end else if (st.scan_end) begin
          cmd.sweep_start = 1'b1;
          state_next      = S_SWEEP;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_HIT_WR: begin
        if (st.out_free) begin
          cmd.hit_commit = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (st.victim) begin
          state_next = S_MISS_WR;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      S_MISS_WR: begin
        if (st.out_free) begin
          cmd.miss_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_FL_SCAN: begin
        if (st.fl_dirty) begin
          state_next = S_FL_TAKE;
        end else if (st.idx_end) begin
          state_next = S_FL_END;
        end else begin
          cmd.fl_step = 1'b1;
        end
      end
      S_FL_TAKE: begin
        if (!st.pend_valid || st.out_free) begin
          cmd.fl_take = 1'b1;
          state_next  = (st.k_limit || st.idx_end) ? S_FL_END : S_FL_SCAN;
        end
      end
      S_FL_END: begin
        if (!st.pend_valid || st.out_free) begin
          cmd.fl_finish = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[design/scc_dp.sv]
// ----------------------------------------------------------------------------
// scc_dp
// Tag memory, per-entry valid/dirty/reference bits, clock hand, flush
// holding stage and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_dp
  import scc_pkg::*;
#(
  parameter int ENTRIES = SCC_ENTRIES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic [SECTOR_W-1:0]  sector,
  input  wire scc_cmd_t             cmd,
  output scc_status_t               st,
  input  wire logic                 rsp_stall,
  output logic                      rsp_valid,
  output logic                      hit,
  output logic [OUT_IDX_W-1:0]      entry_index,
  output logic                      writeback,
  output logic [SECTOR_W-1:0]       writeback_sector,
  output logic                      fill,
  output logic                      last
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int EXT_W = IDX_W + OUT_IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  logic [SECTOR_W-1:0] tag_mem [ENTRIES];
  logic [SECTOR_W-1:0] tag_rd;
  logic [ENTRIES-1:0]  valid_bits;
  logic [ENTRIES-1:0]  dirty_bits;
  logic [ENTRIES-1:0]  ref_bits;
  logic [IDX_W-1:0]    hand;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    idx_q;
  logic                valid_q;
  logic                p_q;
  logic [K_W-1:0]      k;
  logic                req_write;
  logic [SECTOR_W-1:0] req_sector;
  logic                pend_valid;
  logic [IDX_W-1:0]    pend_idx;
  logic [SECTOR_W-1:0] pend_tag;
  logic                old_dirty;
  logic                emit_pend;
  logic                emit;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] x);
    return (x == IDX_LAST) ? '0 : x + 1'b1;
  endfunction

  function automatic logic [OUT_IDX_W-1:0] to_out(input logic [IDX_W-1:0] x);
    logic [EXT_W-1:0] e;
    e = EXT_W'(x);
    return e[OUT_IDX_W-1:0];
  endfunction

  assign old_dirty = valid_bits[idx] && dirty_bits[idx];
  assign emit_pend = pend_valid && (cmd.fl_take || cmd.fl_finish);
  assign emit      = cmd.hit_commit || cmd.miss_commit || emit_pend;

  always_comb begin
    st.match      = p_q && valid_q && (tag_rd == req_sector);
    st.scan_end   = p_q && (idx_q == IDX_LAST);
    st.victim     = !valid_bits[idx] || !ref_bits[idx];
    st.fl_dirty   = old_dirty;
    st.idx_end    = (idx == IDX_LAST);
    st.k_limit    = (k == K_W'(MAX_OUT - 1));
    st.pend_valid = pend_valid;
    st.out_free   = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    tag_rd <= tag_mem[idx];
    if (cmd.miss_commit) begin
      tag_mem[idx] <= req_sector;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      dirty_bits <= '0;
      ref_bits   <= '0;
      hand       <= '0;
      idx        <= '0;
      p_q        <= 1'b0;
      k          <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.load_req) begin
        idx <= '0;
        p_q <= 1'b0;
        k   <= '0;
      end
      if (cmd.scan_step) begin
        p_q <= 1'b1;
        idx <= next_idx(idx);
      end
      if (cmd.sweep_start) begin
        idx <= hand;
      end
      if (cmd.sweep_step) begin
        ref_bits[idx] <= 1'b0;
        idx           <= next_idx(idx);
      end
      if (cmd.hit_commit) begin
        ref_bits[idx_q] <= 1'b1;
        if (req_write) begin
          dirty_bits[idx_q] <= 1'b1;
        end
      end
      if (cmd.miss_commit) begin
        valid_bits[idx] <= 1'b1;
        ref_bits[idx]   <= 1'b1;
        dirty_bits[idx] <= req_write;
        hand            <= next_idx(idx);
      end
      if (cmd.fl_step) begin
        idx <= next_idx(idx);
      end
      if (cmd.fl_take) begin
        valid_bits[idx] <= 1'b0;
        dirty_bits[idx] <= 1'b0;
        ref_bits[idx]   <= 1'b0;
        pend_valid      <= 1'b1;
        k               <= k + 1'b1;
        idx             <= next_idx(idx);
      end
      if (cmd.fl_finish) begin
        pend_valid <= 1'b0;
      end
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_write  <= (func == FUNC_WRITE);
      req_sector <= sector;
    end
    if (cmd.scan_step) begin
      idx_q   <= idx;
      valid_q <= valid_bits[idx];
    end
    if (cmd.fl_take) begin
      pend_idx <= idx;
      pend_tag <= tag_rd;
    end
    if (cmd.hit_commit) begin
      hit              <= 1'b1;
      entry_index      <= to_out(idx_q);
      writeback        <= 1'b0;
      writeback_sector <= '0;
      fill             <= 1'b0;
      last             <= 1'b1;
    end else if (cmd.miss_commit) begin
      hit              <= 1'b0;
      entry_index      <= to_out(idx);
      writeback        <= old_dirty;
      writeback_sector <= old_dirty ? tag_rd : '0;
      fill             <= 1'b1;
      last             <= 1'b1;
    end else if (emit_pend) begin
      hit              <= 1'b0;
      entry_index      <= to_out(pend_idx);
      writeback        <= 1'b1;
      writeback_sector <= pend_tag;
      fill             <= 1'b0;
      last             <= cmd.fl_finish;
    end
  end

endmodule

`default_nettype wire

[design/sector_cache_clock_policy.sv]
// ----------------------------------------------------------------------------
// sector_cache_clock_policy
// Tag and clock replacement engine for a fully associative sector cache.
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   func, sector
//   rsp       out        rsp_valid/rsp_stall   hit, entry_index, writeback,
//                                              writeback_sector, fill, last
//
// The tag memory is read one entry per cycle; lookup walks it from entry 0.
// A hit stops the lookup at the matching entry, then commits in the hit state. A miss
// looks up every entry, sweeps the clock hand to a victim, then refills it.
// Flush walks the entries from entry 0 and emits a writeback word per dirty entry.
// Reset clears valid, dirty and reference bits and the hand at once.
// A stalled rsp word holds; the next req is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sector_cache_clock_policy
  import scc_pkg::*;
#(
  parameter int ENTRIES = SCC_ENTRIES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic [FUNC_W-1:0]    func,
  input  wire logic [SECTOR_W-1:0]  sector,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output logic                      hit,
  output logic [OUT_IDX_W-1:0]      entry_index,
  output logic                      writeback,
  output logic [SECTOR_W-1:0]       writeback_sector,
  output logic                      fill,
  output logic                      last
);

  scc_cmd_t    cmd;
  scc_status_t st;

  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .func      (func),
    .req_stall (req_stall),
    .st        (st),
    .cmd       (cmd)
  );

  scc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .func             (func),
    .sector           (sector),
    .cmd              (cmd),
    .st               (st),
    .rsp_stall        (rsp_stall),
    .rsp_valid        (rsp_valid),
    .hit              (hit),
    .entry_index      (entry_index),
    .writeback        (writeback),
    .writeback_sector (writeback_sector),
    .fill             (fill),
    .last             (last)
  );

  `ASSERT_CLK(a_rst_no_rsp, clk, rst |=> !rsp_valid, "rsp word valid after reset")
  `ASSERT_CLK_RST(a_access_busy, clk, rst, req_valid && !req_stall && (func == FUNC_READ || func == FUNC_WRITE) |=> req_stall, "access not held busy")
  `ASSERT_CLK_RST(a_hit_clean, clk, rst, rsp_valid && hit |-> !writeback && !fill && last, "hit word with writeback or fill")
  `ASSERT_CLK_RST(a_flush_wb, clk, rst, rsp_valid && !hit && !fill |-> writeback, "flush word without writeback")
  `ASSERT_CLK_RST(a_wb_sector, clk, rst, rsp_valid && !writeback |-> writeback_sector == '0, "writeback sector set without writeback")

endmodule

`default_nettype wire
